// ===== design/ladder_key_debounce_long_press_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the ladder key debouncer
// Concurrent checks that vanish when the design is built for synthesis.
// ---------------------------------------------------------------------------
`ifndef LADDER_KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define LADDER_KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH

`ifndef SYNTHESIS
`define LKD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ladder key debouncer: assertion failed");
`define LKD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ladder key debouncer: assertion failed");
`else
`define LKD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LKD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/lkd_pkg.sv =====
// ---------------------------------------------------------------------------
// Ladder key debouncer package
// Key and event codes, limits and the result record shared by the modules.
// ---------------------------------------------------------------------------
package lkd_pkg;

  localparam int ADC_BITS        = 12;
  localparam int REPEAT_INTERVAL = 10;
  localparam int WINDOW_W        = 24;
  localparam int LIMIT_W         = 7;
  localparam int NUM_WINDOWS     = 6;
  localparam int NUM_REGS        = 8;

  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 7'd50;
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 7'd100;

  localparam logic [2:0] REG_SHORT_LIMIT = 3'd6;
  localparam logic [2:0] REG_LONG_LIMIT  = 3'd7;

  localparam logic [3:0] KEY_NONE  = 4'd0;
  localparam logic [3:0] KEY_ONE   = 4'd1;
  localparam logic [3:0] KEY_FOUR  = 4'd4;
  localparam logic [3:0] KEY_MODE  = 4'd5;
  localparam logic [3:0] KEY_SIX   = 4'd6;
  localparam logic [3:0] KEY_SEVEN = 4'd7;
  localparam logic [3:0] KEY_EIGHT = 4'd8;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_PRESS  = 3'd1;
  localparam logic [2:0] EV_SHORT  = 3'd2;
  localparam logic [2:0] EV_LONG   = 3'd3;
  localparam logic [2:0] EV_REPEAT = 3'd4;

  typedef struct packed {
    logic [LIMIT_W-1:0] short_limit;
    logic [LIMIT_W-1:0] long_limit;
  } limits_t;

  typedef struct packed {
    logic [3:0] decoded_key;
    logic [2:0] event_kind;
    logic [3:0] event_key;
  } result_t;

endpackage

// ===== design/ladder_key_debounce_long_press.sv =====
// ---------------------------------------------------------------------------
// Ladder key debouncer with long press and auto-repeat
// Path: an accepted input is held in the input register; its result is registered when the output can take it.
// Throughput: one transaction per cycle while the output is not stalled, set by the input and result registers.
// Reset: synchronous; windows clear, limits load 50 and 100, debouncer idles.
// ---------------------------------------------------------------------------
`include "ladder_key_debounce_long_press_macros.svh"

module ladder_key_debounce_long_press #(
  parameter int ADC_BITS = lkd_pkg::ADC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // adc_sample, pilot_pin, power_pin, zero padding
  input  logic [((ADC_BITS + 9) / 8) * 8 - 1:0] in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // decoded_key, event_key
  output logic [7:0]                           out_tdata,
  // event_kind
  output logic [2:0]                           out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wr_en,
  input  logic [2:0]                           cfg_index,
  input  logic [lkd_pkg::WINDOW_W-1:0]         cfg_wdata
);

  logic [lkd_pkg::NUM_WINDOWS-1:0][lkd_pkg::WINDOW_W-1:0] window_r;
  lkd_pkg::limits_t    limits_r;
  logic                s1_valid_r;
  logic [ADC_BITS-1:0] s1_adc_r;
  logic                s1_pilot_r;
  logic                s1_power_r;
  logic                out_valid_r;
  lkd_pkg::result_t    out_res_r;
  lkd_pkg::result_t    res;
  logic [3:0]          key;
  logic                advance;
  logic                in_accept;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r             <= '0;
      limits_r.short_limit <= lkd_pkg::SHORT_LIMIT_RST;
      limits_r.long_limit  <= lkd_pkg::LONG_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lkd_pkg::REG_SHORT_LIMIT: limits_r.short_limit <= cfg_wdata[lkd_pkg::LIMIT_W-1:0];
        lkd_pkg::REG_LONG_LIMIT:  limits_r.long_limit  <= cfg_wdata[lkd_pkg::LIMIT_W-1:0];
        default:                  window_r[cfg_index]  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_adc_r   <= in_tdata[ADC_BITS-1:0];
      s1_pilot_r <= in_tdata[ADC_BITS];
      s1_power_r <= in_tdata[ADC_BITS+1];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  lkd_decoder #(
    .ADC_BITS (ADC_BITS)
  ) u_decoder (
    .adc_sample (s1_adc_r),
    .pilot_pin  (s1_pilot_r),
    .power_pin  (s1_power_r),
    .windows    (window_r),
    .key        (key)
  );

  lkd_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .key     (key),
    .limits  (limits_r),
    .res     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.event_key, out_res_r.decoded_key};
  assign out_tuser  = out_res_r.event_kind;

  `LKD_ASSERT_IMP(a_no_event_no_key, clk, rst_n,
    out_tvalid && out_tuser == lkd_pkg::EV_NONE, out_tdata[7:4] == lkd_pkg::KEY_NONE)
  `LKD_ASSERT_IMP(a_press_own_key, clk, rst_n,
    out_tvalid && out_tuser == lkd_pkg::EV_PRESS, out_tdata[7:4] == out_tdata[3:0])
  `LKD_ASSERT_IMP(a_stall_blocks_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_tready, !in_tready)
  `LKD_ASSERT_NXT(a_advance_fills_output, clk, rst_n, advance, out_tvalid)

endmodule

// ===== design/lkd_decoder.sv =====
// ---------------------------------------------------------------------------
// Ladder key decoder
// Matches the sample against six windows in priority order, then the pins.
// ---------------------------------------------------------------------------
module lkd_decoder #(
  parameter int ADC_BITS = lkd_pkg::ADC_BITS
) (
  input  logic [ADC_BITS-1:0]                                    adc_sample,
  input  logic                                                   pilot_pin,
  input  logic                                                   power_pin,
  input  logic [lkd_pkg::NUM_WINDOWS-1:0][lkd_pkg::WINDOW_W-1:0] windows,
  output logic [3:0]                                             key
);

  localparam int EXT_W = (2 * ADC_BITS > lkd_pkg::WINDOW_W) ? 2 * ADC_BITS
                                                              : lkd_pkg::WINDOW_W;

  logic [EXT_W-1:0]    w_ext [lkd_pkg::NUM_WINDOWS];
  logic [ADC_BITS-1:0] lo    [lkd_pkg::NUM_WINDOWS];
  logic [ADC_BITS-1:0] hi    [lkd_pkg::NUM_WINDOWS];

  always_comb begin
    for (int n = 0; n < lkd_pkg::NUM_WINDOWS; n++) begin
      w_ext[n] = EXT_W'(windows[n]);
      lo[n]    = w_ext[n][ADC_BITS-1:0];
      hi[n]    = w_ext[n][2*ADC_BITS-1:ADC_BITS];
    end
  end

  always_comb begin
    if (!pilot_pin) begin
      key = lkd_pkg::KEY_SEVEN;
    end else if (power_pin) begin
      key = lkd_pkg::KEY_EIGHT;
    end else begin
      key = lkd_pkg::KEY_NONE;
    end
    // Walk downwards so that the lowest matching window wins.
    for (int n = lkd_pkg::NUM_WINDOWS - 1; n >= 0; n--) begin
      if (adc_sample > lo[n] && adc_sample < hi[n]) begin
        key = 4'(n + 1);
      end
    end
  end

endmodule

// ===== design/lkd_fsm.sv =====
// ---------------------------------------------------------------------------
// Debounce and event state machine
// Tracks the held key, counts hold and repeat ticks and forms one event.
// ---------------------------------------------------------------------------
module lkd_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [3:0]       key,
  input  lkd_pkg::limits_t limits,
  output lkd_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DOWN,
    PH_SURE,
    PH_WAIT
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] prev_key_r;
  logic [lkd_pkg::LIMIT_W-1:0] hold_r, hold_nxt;
  logic [3:0] rep_r, rep_nxt;
  logic       short_seen_r, short_seen_nxt;
  logic       long_seen_r, long_seen_nxt;
  logic       rel_pend_r, rel_pend_nxt;
  logic [3:0] latched_r, latched_nxt;
  logic [2:0] kind;
  logic [3:0] ekey;
  logic [4:0] rep_cnt;
  logic       stay;

  function automatic logic is_arrow(input logic [3:0] k);
    return (k >= lkd_pkg::KEY_ONE) && (k <= lkd_pkg::KEY_FOUR);
  endfunction

  function automatic logic has_long(input logic [3:0] k);
    return is_arrow(k) || (k == lkd_pkg::KEY_SIX) || (k == lkd_pkg::KEY_EIGHT);
  endfunction

  always_comb begin
    phase_nxt      = phase_r;
    hold_nxt       = hold_r;
    rep_nxt        = rep_r;
    short_seen_nxt = short_seen_r;
    long_seen_nxt  = long_seen_r;
    rel_pend_nxt   = rel_pend_r;
    latched_nxt    = latched_r;
    kind           = lkd_pkg::EV_NONE;
    ekey           = lkd_pkg::KEY_NONE;
    rep_cnt        = {1'b0, rep_r} + 5'd1;
    stay           = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        hold_nxt = '0;
        if (key != lkd_pkg::KEY_NONE) begin
          phase_nxt = PH_DOWN;
        end
      end
      PH_DOWN: begin
        phase_nxt = (key == prev_key_r) ? PH_SURE : PH_IDLE;
      end
      PH_SURE: begin
        if (key == prev_key_r) begin
          if (is_arrow(key)) begin
            stay = hold_r < limits.short_limit;
          end else if (key == lkd_pkg::KEY_SIX || key == lkd_pkg::KEY_EIGHT) begin
            stay = hold_r < limits.long_limit;
          end
          if (stay) begin
            hold_nxt = hold_r + lkd_pkg::LIMIT_W'(1);
          end else begin
            phase_nxt = PH_WAIT;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (key != prev_key_r) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    unique case (phase_nxt)
      PH_SURE: begin
        if (key == lkd_pkg::KEY_MODE || key == lkd_pkg::KEY_SEVEN) begin
          kind = lkd_pkg::EV_PRESS;
          ekey = key;
        end
        if (!short_seen_r) begin
          short_seen_nxt = 1'b1;
          rel_pend_nxt   = 1'b1;
          latched_nxt    = key;
        end
      end
      PH_IDLE: begin
        short_seen_nxt = 1'b0;
        long_seen_nxt  = 1'b0;
        rep_nxt        = '0;
        if (rel_pend_r) begin
          rel_pend_nxt = 1'b0;
          latched_nxt  = lkd_pkg::KEY_NONE;
          if (has_long(latched_r)) begin
            kind = lkd_pkg::EV_SHORT;
            ekey = latched_r;
          end
        end
      end
      PH_WAIT: begin
        if (!long_seen_r) begin
          long_seen_nxt = 1'b1;
          rel_pend_nxt  = 1'b0;
          if (has_long(key)) begin
            kind = lkd_pkg::EV_LONG;
            ekey = key;
          end
        end
        if (rep_cnt > 5'(lkd_pkg::REPEAT_INTERVAL)) begin
          rep_nxt = '0;
          if (kind == lkd_pkg::EV_NONE && is_arrow(latched_r)) begin
            kind = lkd_pkg::EV_REPEAT;
            ekey = latched_r;
          end
        end else begin
          rep_nxt = rep_cnt[3:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign res.decoded_key = key;
  assign res.event_kind  = kind;
  assign res.event_key   = ekey;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      prev_key_r   <= lkd_pkg::KEY_NONE;
      hold_r       <= '0;
      rep_r        <= '0;
      short_seen_r <= 1'b0;
      long_seen_r  <= 1'b0;
      rel_pend_r   <= 1'b0;
      latched_r    <= lkd_pkg::KEY_NONE;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      prev_key_r   <= key;
      hold_r       <= hold_nxt;
      rep_r        <= rep_nxt;
      short_seen_r <= short_seen_nxt;
      long_seen_r  <= long_seen_nxt;
      rel_pend_r   <= rel_pend_nxt;
      latched_r    <= latched_nxt;
    end
  end

endmodule
